// ===== rtl/sliding_window_median_assert.svh =====
// Assertion macros for the checker file of the sliding window median.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SWM_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SWM_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window median filter.
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DROP,
    OP_PACK,
    OP_INSERT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_PACK,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/swm_cell.sv =====
// One cell of the sorted chain: holds a sample, its age and an occupancy bit.
module swm_cell
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int IDX        = 0,
  localparam int AGE_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int LEN_W     = $clog2(WINDOW_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  op_t               op,
  input  logic [DATA_W-1:0] sample,
  input  logic [LEN_W-1:0]  len,
  input  logic [AGE_W-1:0]  tgt_idx,
  input  logic [AGE_W-1:0]  last_idx,
  input  logic              lo_valid,
  input  logic [DATA_W-1:0] lo_value,
  input  logic [AGE_W-1:0]  lo_age,
  input  logic              lo_lt,
  input  logic              lo_gap,
  input  logic              up_valid,
  input  logic [DATA_W-1:0] up_value,
  input  logic [AGE_W-1:0]  up_age,
  output logic              valid,
  output logic [DATA_W-1:0] value,
  output logic [AGE_W-1:0]  age,
  output logic              lt,
  output logic              med_hit,
  output logic              last_hit
);

  logic expire;

  assign lt       = valid && (value < sample);
  assign expire   = (LEN_W'(age) + LEN_W'(1)) >= len;
  assign med_hit  = (tgt_idx == AGE_W'(IDX));
  assign last_hit = valid && (last_idx == AGE_W'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        OP_DROP: begin
          if (valid) begin
            if (expire) begin
              valid <= 1'b0;
            end else begin
              age <= age + AGE_W'(1);
            end
          end
        end
        OP_PACK: begin
          // A gap here or anywhere below: everything above moves down by one place.
          if (!valid || lo_gap) begin
            valid <= up_valid;
            value <= up_value;
            age   <= up_age;
          end
        end
        OP_INSERT: begin
          if (!lt) begin
            if (lo_lt) begin
              valid <= 1'b1;
              value <= sample;
              age   <= '0;
            end else begin
              valid <= lo_valid;
              value <= lo_value;
              age   <= lo_age;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/sliding_window_median.sv =====
// A sample beat is taken only while the block is idle. It is worked through the drop, compact,
// insert and select steps in that order; compaction repeats until the gaps left by expired cells
// are closed. The next sample beat is not taken until the current one has left the select step,
// and a stalled result beat holds select. No result beat is given until the window is full.
// Reset (rst, synchronous) empties every cell, sets window_length to 1 and clears m_tvalid.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] sample
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] median_value
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata  // window_length
);

  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  state_t state, state_next;
  op_t    op;
  logic   load;

  logic [CFG_W-1:0]  window_length;
  logic [DATA_W-1:0] sample_q;
  logic [CMP_W-1:0]  len_cmp;
  logic [LEN_W-1:0]  len;
  logic [AGE_W-1:0]  tgt_idx;
  logic [AGE_W-1:0]  last_idx;

  logic              cell_valid [WINDOW_MAX];
  logic [DATA_W-1:0] cell_value [WINDOW_MAX];
  logic [AGE_W-1:0]  cell_age   [WINDOW_MAX];
  logic              cell_lt    [WINDOW_MAX];
  logic              cell_med   [WINDOW_MAX];
  logic              cell_last  [WINDOW_MAX];

  logic [WINDOW_MAX-1:0] gap_below;
  logic                  pack_need;
  logic                  full;
  logic [DATA_W-1:0]     med;

  // Zero is taken as one; anything above the chain depth as the chain depth.
  always_comb begin
    len_cmp = CMP_W'(window_length);
    if (len_cmp == '0) begin
      len_cmp = CMP_W'(1);
    end else if (len_cmp > CMP_W'(WINDOW_MAX)) begin
      len_cmp = CMP_W'(WINDOW_MAX);
    end
  end

  assign len      = LEN_W'(len_cmp);
  assign last_idx = AGE_W'(len - LEN_W'(1));
  assign tgt_idx  = AGE_W'((len - LEN_W'(1)) >> 1);

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic              lo_valid, lo_lt, up_valid;
    logic [DATA_W-1:0] lo_value, up_value;
    logic [AGE_W-1:0]  lo_age, up_age;

    if (j == 0) begin : g_lo_edge
      assign lo_valid = 1'b1;
      assign lo_lt    = 1'b1;
      assign lo_value = '0;
      assign lo_age   = '0;
    end else begin : g_lo
      assign lo_valid = cell_valid[j-1];
      assign lo_lt    = cell_lt[j-1];
      assign lo_value = cell_value[j-1];
      assign lo_age   = cell_age[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_up_edge
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_age   = '0;
    end else begin : g_up
      assign up_valid = cell_valid[j+1];
      assign up_value = cell_value[j+1];
      assign up_age   = cell_age[j+1];
    end

    swm_cell #(
      .WINDOW_MAX (WINDOW_MAX),
      .IDX        (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .sample   (sample_q),
      .len      (len),
      .tgt_idx  (tgt_idx),
      .last_idx (last_idx),
      .lo_valid (lo_valid),
      .lo_value (lo_value),
      .lo_age   (lo_age),
      .lo_lt    (lo_lt),
      .lo_gap   (gap_below[j]),
      .up_valid (up_valid),
      .up_value (up_value),
      .up_age   (up_age),
      .valid    (cell_valid[j]),
      .value    (cell_value[j]),
      .age      (cell_age[j]),
      .lt       (cell_lt[j]),
      .med_hit  (cell_med[j]),
      .last_hit (cell_last[j])
    );
  end

  always_comb begin
    pack_need    = 1'b0;
    full         = 1'b0;
    med          = '0;
    gap_below[0] = 1'b0;
    // Each cell learns whether any cell beneath it is empty.
    for (int j = 1; j < WINDOW_MAX; j++) begin
      gap_below[j] = gap_below[j-1] | !cell_valid[j-1];
    end
    for (int j = 0; j < WINDOW_MAX - 1; j++) begin
      pack_need = pack_need | (!cell_valid[j] && cell_valid[j+1]);
    end
    for (int j = 0; j < WINDOW_MAX; j++) begin
      full = full | cell_last[j];
      med  = med | (cell_med[j] ? cell_value[j] : '0);
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_HOLD;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DROP;
        end
      end
      ST_DROP: begin
        op         = OP_DROP;
        state_next = ST_PACK;
      end
      ST_PACK: begin
        if (pack_need) begin
          op = OP_PACK;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        op         = OP_INSERT;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // The window is full exactly when the cell at place len-1 is occupied.
        if (!full) begin
          state_next = ST_IDLE;
        end else if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(1);
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_wdata;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_q <= s_tdata;
    end
    if (load) begin
      m_tdata <= med;
    end
  end

endmodule

// ===== rtl/swm_checker.sv =====
// Port-level checker for the sliding window median filter, bound to the top level.
`include "sliding_window_median_assert.svh"

module swm_checker
  import swm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  `SWM_ASSERT_NEXT(a_reset_out_idle, clk, 1'b0, rst, !m_tvalid, "result beat pending after reset")
  `SWM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")
  `SWM_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second sample beat taken while one is in work")
  `SWM_ASSERT_NOW(a_result_from_work, clk, rst, $rose(m_tvalid), !$past(s_tready), "result beat appeared while the chain was idle")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the sliding window median filter.
module testbench;
  import swm_pkg::*;

  localparam int WINDOW_LIMIT = WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 17;
  localparam int PHASE_BEATS = 100;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int sender_idle_pct;
  int receiver_stall_pct;
  int cycles;

  // Keeps the recent samples, newest first, and the medians still owed by the block.
  class median_scoreboard;
    logic [DATA_W-1:0] history[$];
    logic [DATA_W-1:0] medians[$];
    int unsigned span;
    int errors;

    function new();
      span = 1;
      errors = 0;
    endfunction

    function void set_length(logic [CFG_W-1:0] len);
      if (len == 0) span = 1;
      else if (len > WINDOW_LIMIT) span = WINDOW_LIMIT;
      else span = 32'(len);
    endfunction

    function void note_sample(logic [DATA_W-1:0] value);
      int unsigned rank;
      int unsigned below;
      int unsigned upto;
      history.push_front(value);
      while (history.size() > span) void'(history.pop_back());
      if (history.size() == span) begin
        rank = (span + 1) / 2;
        // Pick the value whose run of equal entries covers the wanted rank.
        for (int i = 0; i < history.size(); i++) begin
          below = 0;
          upto = 0;
          for (int j = 0; j < history.size(); j++) begin
            if (history[j] < history[i]) below++;
            if (history[j] <= history[i]) upto++;
          end
          if (below < rank && rank <= upto) begin
            medians.push_back(history[i]);
            break;
          end
        end
      end
    endfunction

    task report(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
    endtask

    task check_median(input logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (medians.size() == 0) begin
        report($sformatf("median_value %h with none pending", got));
      end else begin
        want = medians.pop_front();
        if (got !== want)
          report($sformatf("median_value %h, wanted %h", got, want));
      end
    endtask
  endclass

  median_scoreboard sb;

  sliding_window_median uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side: check every accepted beat, then decide whether to stall the next one.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_median(m_tdata);
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] value;
    case ($urandom_range(3))
      0: value = $urandom;
      1: value = $urandom_range(7);
      2: value = 32'hFFFF_FFF0 + $urandom_range(15);
      default: begin
        case ($urandom_range(3))
          0: value = 32'h0000_0000;
          1: value = 32'hFFFF_FFFF;
          2: value = 32'h8000_0000;
          default: value = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    return value;
  endfunction

  task automatic send_sample(input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(value);
  endtask

  task automatic wait_drained();
    while (sb.medians.size() != 0) @(posedge clk);
  endtask

  // The block may still be compacting after its last result, so let it settle first.
  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    sb.set_length(len);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      1: begin sender_idle_pct = 76; receiver_stall_pct = 0; end
      2: begin sender_idle_pct = 0; receiver_stall_pct = 76; end
      default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
    endcase
  endtask

  initial begin
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] fixed_lengths[8];
    sb = new();
    cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    fixed_lengths = '{7'd64, 7'd127, 7'd3, 7'd0, 7'd96, 7'd1, 7'd2, 7'd33};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Length left at its reset value of one: each sample is its own median.
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    s_tvalid <= 1'b0;

    // Even length gives the lower of the two middle values.
    set_idling(3);
    write_length(7'd2);
    send_sample(32'd10);
    send_sample(32'd20);
    send_sample(32'd5);
    send_sample(32'd5);
    s_tvalid <= 1'b0;

    // Growing the window holds results back until it has refilled; ties count per entry.
    write_length(7'd5);
    send_sample(32'd9);
    send_sample(32'd9);
    send_sample(32'd1);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd9);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    s_tvalid <= 1'b0;

    // Shrinking drops the oldest entries at once; zero behaves as one.
    set_idling(0);
    write_length(7'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    s_tvalid <= 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 8) len = fixed_lengths[p];
      else if ($urandom_range(2) == 0) len = CFG_W'($urandom_range(64, 1));
      else len = CFG_W'($urandom_range(12, 1));
      set_idling(p % 4);
      write_length(len);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // Now and then the source holds off until the block has caught up.
        if ((p == 5 || p == 10) && i == PHASE_BEATS / 2) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        send_sample(pick_sample());
      end
      s_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.medians.size() != 0)
      sb.report($sformatf("%0d medians never arrived", sb.medians.size()));
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
